/* hdl/dq_pkg.sv */
// Shared types and constants for the bounded deque.
package dq_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned TdataW = 40;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } dq_op_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } dq_status_e;

  // Broadcast controls for the row of cells
  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_back;
    logic gather_load;
    logic gather_shift;
  } dq_cell_ctrl_t;

endpackage

/* hdl/bounded_deque.sv */
// Bounded deque top level: controller plus a row of DEPTH storage cells.
// Words sit in a row of cells with the front word always in cell 0: a push or
// pop at the front shifts the whole row by one cell, a push at the back writes
// the cell whose index equals the fill count. Push front, push back, pop front
// and every refused request (push when full, pop when empty) are answered in the
// cycle after they are taken. A pop at the back of a deque holding more than one
// word copies the row into a gather chain and the tail word steps one cell per cycle
// toward cell 0. One request is in flight at a time; a finished result waits in
// the output register and the next request is taken as soon as it is drained.
module bounded_deque #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [1:0] op, [33:2] push_value, [39:34] zero
  input  logic [dq_pkg::TdataW-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [1:0] status, [33:2] pop_value, [39:34] zero
  output logic [dq_pkg::TdataW-1:0]   m_axis_tdata
);
  import dq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  dq_cell_ctrl_t   cell_ctrl;
  logic [CntW-1:0] cnt;
  dq_op_e          op;
  logic [ValW-1:0] push_value;
  logic [ValW-1:0] data   [DEPTH];
  logic [ValW-1:0] gath   [DEPTH];
  dq_status_e      out_status;
  logic [ValW-1:0] out_value;

  assign op         = dq_op_e'(s_axis_tdata[1:0]);
  assign push_value = s_axis_tdata[ValW+1:2];

  dq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (op),
    .head_data_i  (data[0]),
    .head_gath_i  (gath[0]),
    .ctrl_o       (cell_ctrl),
    .cnt_o        (cnt),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_value_o  (out_value)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ValW-1:0] prev_data, next_data, next_gath;
    if (i == 0) begin : g_first
      assign prev_data = push_value;
    end else begin : g_mid
      assign prev_data = data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_data = '0;
      assign next_gath = '0;
    end else begin : g_inner
      assign next_data = data[i+1];
      assign next_gath = gath[i+1];
    end
    dq_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .cnt_i        (cnt),
      .push_value_i (push_value),
      .prev_data_i  (prev_data),
      .next_data_i  (next_data),
      .next_gath_i  (next_gath),
      .data_o       (data[i]),
      .gath_o       (gath[i])
    );
  end

  assign m_axis_tdata = {(TdataW - ValW - 2)'(0), out_value, out_status};

endmodule

/* hdl/dq_cell.sv */
// One storage cell of the deque row, with its word and a gather stage.
module dq_cell #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned IDX   = 0,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                      clk_i,
  input  dq_pkg::dq_cell_ctrl_t     ctrl_i,
  input  logic [CntW-1:0]           cnt_i,
  input  logic [dq_pkg::ValW-1:0]   push_value_i,
  input  logic [dq_pkg::ValW-1:0]   prev_data_i,
  input  logic [dq_pkg::ValW-1:0]   next_data_i,
  input  logic [dq_pkg::ValW-1:0]   next_gath_i,
  output logic [dq_pkg::ValW-1:0]   data_o,
  output logic [dq_pkg::ValW-1:0]   gath_o
);
  import dq_pkg::*;

  logic [ValW-1:0] data_q, data_d;
  logic [ValW-1:0] gath_q, gath_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.push_front) begin
      data_d = prev_data_i;
    end else if (ctrl_i.pop_front) begin
      data_d = next_data_i;
    end else if (ctrl_i.push_back && (cnt_i == CntW'(IDX))) begin
      data_d = push_value_i;
    end
  end

  always_comb begin
    gath_d = gath_q;
    if (ctrl_i.gather_load) begin
      gath_d = data_q;
    end else if (ctrl_i.gather_shift) begin
      gath_d = next_gath_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    gath_q <= gath_d;
  end

  assign data_o = data_q;
  assign gath_o = gath_q;

endmodule

/* hdl/dq_ctrl.sv */
// Deque controller: fill count, cell controls, tail gather and result register.
module dq_ctrl #(
  parameter int unsigned DEPTH = 8,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  dq_pkg::dq_op_e            op_i,
  input  logic [dq_pkg::ValW-1:0]   head_data_i,
  input  logic [dq_pkg::ValW-1:0]   head_gath_i,
  output dq_pkg::dq_cell_ctrl_t     ctrl_o,
  output logic [CntW-1:0]           cnt_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output dq_pkg::dq_status_e        out_status_o,
  output logic [dq_pkg::ValW-1:0]   out_value_o
);
  import dq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_GATHER = 2'b10
  } dq_state_e;

  dq_state_e       state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] gcnt_q, gcnt_d;
  logic            out_valid_q, out_valid_d;
  dq_status_e      out_status_q, out_status_d;
  logic [ValW-1:0] out_value_q, out_value_d;
  logic            accept, full, empty, emit;
  dq_status_e      emit_status;
  logic [ValW-1:0] emit_value;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (cnt_q == CntW'(DEPTH));
  assign empty      = (cnt_q == '0);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    gcnt_d      = gcnt_q;
    ctrl_o      = '0;
    emit        = 1'b0;
    emit_status = STAT_DONE;
    emit_value  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          case (op_i)
            OP_PUSH_FRONT: begin
              if (full) begin
                emit_status = STAT_FULL;
              end else begin
                ctrl_o.push_front = 1'b1;
                cnt_d = cnt_q + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                emit_status = STAT_FULL;
              end else begin
                ctrl_o.push_back = 1'b1;
                cnt_d = cnt_q + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                emit_status = STAT_EMPTY;
              end else begin
                ctrl_o.pop_front = 1'b1;
                emit_value = head_data_i;
                cnt_d = cnt_q - 1'b1;
              end
            end
            default: begin
              if (empty) begin
                emit_status = STAT_EMPTY;
              end else if (cnt_q == CntW'(1)) begin
                emit_value = head_data_i;
                cnt_d = '0;
              end else begin
                // tail word walks down the gather stages to cell 0
                emit = 1'b0;
                ctrl_o.gather_load = 1'b1;
                gcnt_d  = cnt_q - 1'b1;
                cnt_d   = cnt_q - 1'b1;
                state_d = ST_GATHER;
              end
            end
          endcase
        end
      end
      ST_GATHER: begin
        if (gcnt_q == '0) begin
          emit       = 1'b1;
          emit_value = head_gath_i;
          state_d    = ST_IDLE;
        end else begin
          ctrl_o.gather_shift = 1'b1;
          gcnt_d = gcnt_q - 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_status_d = emit_status;
      out_value_d  = emit_value;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      gcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      gcnt_q      <= gcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  assign cnt_o        = cnt_q;
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;

endmodule

/* hdl/dq_checker.sv */
// Port-level checks for the bounded deque, bound to the top level.
module dq_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [dq_pkg::TdataW-1:0] s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [dq_pkg::TdataW-1:0] m_axis_tdata
);
  import dq_pkg::*;

  logic s_accept;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // no new request while a result is stuck at the output
  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while result stalled");

  // refused requests return a zero value
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != STAT_DONE |-> m_axis_tdata[ValW+1:2] == '0)
    else $error("refused request returned nonzero value");

  // a push or front pop answers in the next cycle
  a_fast_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && (s_axis_tdata[1:0] == OP_PUSH_FRONT || s_axis_tdata[1:0] == OP_PUSH_BACK
    || s_axis_tdata[1:0] == OP_POP_FRONT) |=> m_axis_tvalid)
    else $error("missing one-cycle result");

endmodule

bind bounded_deque dq_checker u_dq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* dv/tb_bounded_deque.sv */
// Self-checking testbench for the bounded deque: stream stimulus plus scoreboard.
`timescale 1ns / 1ps

module tb_bounded_deque;
  import dq_pkg::*;

  localparam int unsigned DEPTH     = 8;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandWords = 610;

  // Keeps its own copy of the deque and predicts the reply to every request.
  class deque_scoreboard;
    typedef struct packed {
      dq_status_e  status;
      logic [31:0] value;
    } reply_t;

    logic [31:0] slot_q [DEPTH];
    int unsigned head;
    int unsigned fill;
    reply_t      replies [$];
    int unsigned errors;
    int unsigned n_req;
    int unsigned n_full;
    int unsigned n_empty;
    int unsigned peak_fill;

    function new();
      head      = 0;
      fill      = 0;
      errors    = 0;
      n_req     = 0;
      n_full    = 0;
      n_empty   = 0;
      peak_fill = 0;
    endfunction

    function void note_request(dq_op_e op, logic [31:0] val);
      reply_t r;
      r.status = STAT_DONE;
      r.value  = '0;
      n_req++;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (fill == DEPTH) begin
            r.status = STAT_FULL;
            n_full++;
          end else if (op == OP_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            slot_q[head] = val;
            fill++;
          end else begin
            slot_q[(head + fill) % DEPTH] = val;
            fill++;
          end
        end
        default: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
            n_empty++;
          end else if (op == OP_POP_FRONT) begin
            r.value = slot_q[head];
            head    = (head + 1) % DEPTH;
            fill--;
          end else begin
            r.value = slot_q[(head + fill - 1) % DEPTH];
            fill--;
          end
        end
      endcase
      if (fill > peak_fill) peak_fill = fill;
      replies.push_back(r);
    endfunction

    function void check_reply(logic [1:0] status, logic [31:0] value);
      reply_t exp_r;
      if (replies.size() == 0) begin
        $display("%0t: unexpected reply, status %0d value %08h", $time, status, value);
        errors++;
        return;
      end
      exp_r = replies.pop_front();
      if (status !== exp_r.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, exp_r.status, status);
        errors++;
      end
      if (value !== exp_r.value) begin
        $display("%0t: pop_value mismatch, expected %08h, actual %08h",
                 $time, exp_r.value, value);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_valid;
  logic                s_axis_tready;
  logic [TdataW-1:0]   s_data;
  logic                m_axis_tvalid;
  logic                m_ready;
  logic [TdataW-1:0]   m_axis_tdata;

  deque_scoreboard sb;
  int unsigned     src_gap_max;
  int unsigned     dst_gap_max;
  int unsigned     idle_cycles;

  bounded_deque #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    s_valid     = 1'b0;
    s_data      = '0;
    m_ready     = 1'b0;
    src_gap_max = 8;
    dst_gap_max = 8;
    idle_cycles = 0;
    sb          = new();
  end

  always #5 clk_i = ~clk_i;

  // Returns at the rising edge where the word was taken.
  task automatic send_request(dq_op_e op, logic [31:0] val);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(TdataW - ValW - 2){1'b0}}, val, op};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    sb.note_request(op, val);
  endtask

  // Hold off the sender until every reply is back.
  task automatic drain_replies();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (sb.replies.size() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Sink side: random stall before each word, drawn again after every accept.
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = $urandom_range(0, dst_gap_max);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
      @(posedge clk_i);
    end
  end

  // Signals are settled at the falling edge; the handshake seen here completes
  // at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready) begin
      sb.check_reply(m_axis_tdata[1:0], m_axis_tdata[ValW+1:2]);
    end
    if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, idle_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned n_rand;
    int unsigned phase;
    int unsigned push_pct;
    int unsigned run_len;
    dq_op_e      op;
    bit          front;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty refusals, front wrap, extremes, full refusals, long back pops
    send_request(OP_POP_FRONT, pick_value());
    send_request(OP_POP_BACK, pick_value());
    send_request(OP_PUSH_BACK, 32'h7fff_ffff);
    send_request(OP_PUSH_FRONT, 32'h8000_0000);
    send_request(OP_POP_BACK, 32'h0);
    send_request(OP_POP_FRONT, 32'hffff_ffff);
    send_request(OP_PUSH_FRONT, 32'h0000_0000);
    send_request(OP_PUSH_BACK, 32'hffff_ffff);
    send_request(OP_PUSH_FRONT, 32'h5555_5555);
    send_request(OP_PUSH_BACK, 32'haaaa_aaaa);
    send_request(OP_PUSH_FRONT, 32'h8000_0000);
    send_request(OP_PUSH_BACK, 32'h7fff_ffff);
    send_request(OP_PUSH_FRONT, 32'h0000_0001);
    send_request(OP_PUSH_BACK, 32'h1234_5678);
    send_request(OP_PUSH_FRONT, 32'hdead_beef);
    send_request(OP_PUSH_BACK, 32'hcafe_f00d);
    send_request(OP_POP_BACK, 32'h0);
    send_request(OP_POP_BACK, 32'h0);
    send_request(OP_POP_FRONT, 32'h0);
    send_request(OP_POP_BACK, 32'h0);
    send_request(OP_POP_FRONT, 32'h0);
    send_request(OP_POP_BACK, 32'h0);
    send_request(OP_POP_BACK, 32'h0);
    send_request(OP_POP_FRONT, 32'h0);
    send_request(OP_POP_BACK, 32'h0);

    // Random: runs biased toward filling, draining or balanced traffic
    n_rand = 0;
    phase  = 0;
    while (n_rand < RandWords) begin
      case ($urandom_range(0, 3))
        0:       push_pct = 20;
        1:       push_pct = 80;
        default: push_pct = 50;
      endcase
      src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      dst_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      run_len = 20 + $urandom_range(0, 20);
      repeat (run_len) begin
        front = $urandom_range(0, 1);
        if ($urandom_range(0, 99) < push_pct) begin
          op = front ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else begin
          op = front ? OP_POP_FRONT : OP_POP_BACK;
        end
        send_request(op, pick_value());
        n_rand++;
      end
      if (phase % 4 == 1) drain_replies();
      phase++;
    end

    drain_replies();
    // back pops can keep the block busy while the tail word is gathered
    repeat (4 * DEPTH) @(posedge clk_i);

    $display("Sent %0d requests with random stalls on both sides, peak fill %0d of %0d",
             sb.n_req, sb.peak_fill, DEPTH);
    $display("Refused %0d pushes on a full deque and %0d pops on an empty one",
             sb.n_full, sb.n_empty);
    if (sb.errors == 0 && sb.replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
